/* design/ttpi_pkg.sv */
// Shared types, register map, reset values and the CORDIC arctangent table
// for the trajectory tracking PI controller. No dependencies.
`default_nettype none

package ttpi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int ADDR_W        = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_PREVIEW_DIST,
    REG_PREVIEW_RECIP,
    REG_UPDATE_RATIO,
    REG_MAX_LINEAR,
    REG_MAX_ANGULAR,
    REG_MAX_ANG_RECIP
  } reg_idx_t;

  localparam logic [23:0] RST_PROP_GAIN     = 24'd98304;
  localparam logic [23:0] RST_INTEG_GAIN    = 24'd328;
  localparam logic [23:0] RST_PREVIEW_DIST  = 24'd6554;
  localparam logic [31:0] RST_PREVIEW_RECIP = 32'd655360;
  localparam logic [7:0]  RST_UPDATE_RATIO  = 8'd5;
  localparam logic [23:0] RST_MAX_LINEAR    = 24'd13107;
  localparam logic [23:0] RST_MAX_ANGULAR   = 24'd131072;
  localparam logic [31:0] RST_MAX_ANG_RECIP = 32'd32768;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [23:0] preview_dist;
    logic [31:0] preview_recip;
    logic [7:0]  update_ratio;
    logic [23:0] max_linear;
    logic [23:0] max_angular;
    logic [31:0] max_angular_recip;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_vx;
    logic signed [31:0] ref_vy;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic               pi_updated;
  } out_beat_t;

  // Multiply steps in the order the sequencer issues them.
  typedef enum logic [3:0] {
    OP_PPX, OP_PPY, OP_PX, OP_IX, OP_PY, OP_IY,
    OP_LX, OP_LY, OP_AY, OP_AX, OP_ANG, OP_FAC, OP_LIM
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t op;
    logic    integ;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic run;
    logic cordic_done;
    logic mul_done;
    logic out_busy;
  } dp_sts_t;

  // Arctangent of 2^-i in units where 2^31 is pi.
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

endpackage

`default_nettype wire

/* design/ttpi_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on ttpi_pkg for the register map and reset values.
`default_nettype none

module ttpi_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttpi_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ttpi_pkg::cfg_t               cfg
);
  import ttpi_pkg::*;

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= RST_PROP_GAIN;
      cfg.integ_gain        <= RST_INTEG_GAIN;
      cfg.preview_dist      <= RST_PREVIEW_DIST;
      cfg.preview_recip     <= RST_PREVIEW_RECIP;
      cfg.update_ratio      <= RST_UPDATE_RATIO;
      cfg.max_linear        <= RST_MAX_LINEAR;
      cfg.max_angular       <= RST_MAX_ANGULAR;
      cfg.max_angular_recip <= RST_MAX_ANG_RECIP;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PROP_GAIN:     cfg.prop_gain         <= pwdata[23:0];
        REG_INTEG_GAIN:    cfg.integ_gain        <= pwdata[23:0];
        REG_PREVIEW_DIST:  cfg.preview_dist      <= pwdata[23:0];
        REG_PREVIEW_RECIP: cfg.preview_recip     <= pwdata;
        REG_UPDATE_RATIO:  cfg.update_ratio      <= pwdata[7:0];
        REG_MAX_LINEAR:    cfg.max_linear        <= pwdata[23:0];
        REG_MAX_ANGULAR:   cfg.max_angular       <= pwdata[23:0];
        REG_MAX_ANG_RECIP: cfg.max_angular_recip <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:     prdata = {8'd0, cfg.prop_gain};
      REG_INTEG_GAIN:    prdata = {8'd0, cfg.integ_gain};
      REG_PREVIEW_DIST:  prdata = {8'd0, cfg.preview_dist};
      REG_PREVIEW_RECIP: prdata = cfg.preview_recip;
      REG_UPDATE_RATIO:  prdata = {24'd0, cfg.update_ratio};
      REG_MAX_LINEAR:    prdata = {8'd0, cfg.max_linear};
      REG_MAX_ANGULAR:   prdata = {8'd0, cfg.max_angular};
      REG_MAX_ANG_RECIP: prdata = cfg.max_angular_recip;
    endcase
  end

endmodule

`default_nettype wire

/* design/ttpi_ctrl.sv */
// Sequencer: steps one tick through rotation, the multiply chain and emission.
// Depends on ttpi_pkg for the command and status structs.
`default_nettype none

module ttpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttpi_pkg::dp_sts_t sts,
  output ttpi_pkg::dp_cmd_t cmd
);
  import ttpi_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROT, S_ISSUE, S_WAIT, S_INTEG, S_EMIT} state_t;

  state_t  state;
  mul_op_t op;

  function automatic mul_op_t next_op(input mul_op_t o);
    mul_op_t n;
    unique case (o)
      OP_PPX:  n = OP_PPY;
      OP_PX:   n = OP_IX;
      OP_IX:   n = OP_PY;
      OP_PY:   n = OP_IY;
      OP_IY:   n = OP_LX;
      OP_LX:   n = OP_LY;
      OP_LY:   n = OP_AY;
      OP_AY:   n = OP_AX;
      OP_AX:   n = OP_ANG;
      OP_ANG:  n = OP_FAC;
      OP_FAC:  n = OP_LIM;
      default: n = OP_LIM;
    endcase
    return n;
  endfunction

  assign in_ready      = (state == S_IDLE);
  assign cmd.load      = (state == S_IDLE) && in_valid;
  assign cmd.mul_start = (state == S_ISSUE);
  assign cmd.op        = op;
  assign cmd.integ     = (state == S_INTEG);
  assign cmd.emit      = (state == S_EMIT) && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_PPX;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_ROT;
        end
        S_ROT: begin
          if (sts.cordic_done) begin
            op    <= OP_PPX;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (sts.mul_done) begin
            if (op == OP_PPY) begin
              // Off-update ticks skip straight to the command mapping.
              if (sts.run) begin
                state <= S_INTEG;
              end else begin
                op    <= OP_LX;
                state <= S_ISSUE;
              end
            end else if (op == OP_LIM) begin
              state <= S_EMIT;
            end else begin
              op    <= next_op(op);
              state <= S_ISSUE;
            end
          end
        end
        S_INTEG: begin
          op    <= OP_PX;
          state <= S_ISSUE;
        end
        S_EMIT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ttpi_mulq.sv */
// Multi-cycle rounded fixed-point multiplier sharing one 32x24 product.
// Depends on ttpi_pkg only for the default fraction width.
`default_nettype none

module ttpi_mulq #(
  parameter int FRAC_BITS = ttpi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [48:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic signed [63:0] result
);

  typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_FIN} phase_t;

  localparam int          SH     = 24 - FRAC_BITS;
  localparam logic [63:0] SAT62  = 64'd1 << 62;
  localparam logic [63:0] HI_LIM = SAT62 >> SH;
  localparam logic [63:0] HALF   = 64'd1 << (FRAC_BITS - 1);

  phase_t             phase;
  logic [47:0]        ma;
  logic [31:0]        mb;
  logic               neg;
  logic [55:0]        hi;
  logic [55:0]        lo;
  logic signed [48:0] abs_a;
  logic signed [32:0] abs_b;
  logic [23:0]        mul_sel;
  logic [55:0]        prod;
  logic [63:0]        sum;
  logic [63:0]        r;

  assign abs_a   = a[48] ? -a : a;
  assign abs_b   = b[32] ? -b : b;
  assign mul_sel = (phase == M_HI) ? ma[47:24] : ma[23:0];
  assign prod    = 56'(mb) * 56'(mul_sel);

  always_comb begin
    sum = ({8'd0, hi} << SH) + (({8'd0, lo} + HALF) >> FRAC_BITS);
    if ({8'd0, hi} > HI_LIM) begin
      r = SAT62;
    end else if (sum > SAT62) begin
      r = SAT62;
    end else begin
      r = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        M_IDLE: begin
          if (start) begin
            // Magnitudes are clamped to 48 and 32 bits.
            ma    <= abs_a[48] ? '1 : abs_a[47:0];
            mb    <= abs_b[32] ? '1 : abs_b[31:0];
            neg   <= a[48] != b[32];
            phase <= M_HI;
          end
        end
        M_HI: begin
          hi    <= prod;
          phase <= M_LO;
        end
        M_LO: begin
          lo    <= prod;
          phase <= M_FIN;
        end
        M_FIN: begin
          result <= neg ? -$signed(r) : $signed(r);
          done   <= 1'b1;
          phase  <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ttpi_dp.sv */
// Datapath: CORDIC sine/cosine, operand selection for the shared multiplier,
// PI state, limits and the output register. Depends on ttpi_pkg and ttpi_mulq.
`default_nettype none

module ttpi_dp #(
  parameter int FRAC_BITS = ttpi_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ttpi_pkg::cfg_t      cfg,
  input  ttpi_pkg::in_beat_t  in_data,
  input  ttpi_pkg::dp_cmd_t   cmd,
  output ttpi_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ttpi_pkg::out_beat_t out_data
);
  import ttpi_pkg::*;

  localparam int CS_W   = FRAC_BITS + 2;
  localparam int ROT_W  = 34;
  localparam int DX_W   = 36;
  localparam int LIN_W  = 34;
  localparam int ANG_W  = 25;
  localparam logic signed [ROT_W-1:0] X_INIT  = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] ROUND_C = 34'sd1 <<< (29 - FRAC_BITS);
  localparam logic signed [ROT_W-1:0] ONE_R   = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] V_MAX = 66'sd2147483647;
  localparam logic signed [65:0] V_MIN = -66'sd2147483648;
  localparam logic signed [48:0] I_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] I_MIN = -49'sd140737488355328;
  localparam logic signed [64:0] F_ONE = 65'sd1 <<< FRAC_BITS;

  function automatic logic signed [CS_W-1:0] clamp_unit(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] t;
    if (v > ONE_R) t = ONE_R;
    else if (v < -ONE_R) t = -ONE_R;
    else t = v;
    return t[CS_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] t;
    if (v > V_MAX) t = V_MAX;
    else if (v < V_MIN) t = V_MIN;
    else t = v;
    return t[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [48:0] t;
    if (v > I_MAX) t = I_MAX;
    else if (v < I_MIN) t = I_MIN;
    else t = v;
    return t[47:0];
  endfunction

  // Latched tick inputs.
  logic signed [31:0] px, py, rx, ry, rvx, rvy;

  // Rotation state.
  logic signed [ROT_W-1:0] x, y, z;
  logic [4:0]              iter;
  logic                    rot_busy, flip, cordic_done;
  logic signed [CS_W-1:0]  c, s;

  // PI and command state.
  logic signed [47:0]      integ_x, integ_y;
  logic signed [31:0]      held_vel_x, held_vel_y;
  logic [7:0]              tick_count;
  logic                    run;
  logic signed [DX_W-1:0]  dx, dy;
  logic signed [65:0]      vel_acc;
  logic signed [LIN_W-1:0] lin, diff, lim;
  logic signed [ANG_W-1:0] ang;
  logic [FRAC_BITS:0]      factor;
  mul_op_t                 op_q;

  // Load-time decode.
  logic [31:0]             ang32;
  logic                    quad_flip;
  logic [31:0]             z0;
  logic [7:0]              eff_tick, ratio;
  logic [8:0]              tick_inc;

  assign ang32     = {in_data.heading, 16'h0000};
  assign quad_flip = (ang32[31:30] == 2'b01) || (ang32[31:30] == 2'b10);
  assign z0        = quad_flip ? (ang32 ^ 32'h8000_0000) : ang32;
  assign eff_tick  = in_data.restart ? 8'd0 : tick_count;
  assign ratio     = (cfg.update_ratio == 8'd0) ? 8'd1 : cfg.update_ratio;
  assign tick_inc  = {1'b0, eff_tick} + 9'd1;

  // One CORDIC micro-rotation.
  logic signed [ROT_W-1:0] xs, ys, at, nx, ny, nz, xr, yr;
  logic signed [CS_W-1:0]  cx, sy;

  always_comb begin
    xs = x >>> iter;
    ys = y >>> iter;
    at = $signed({4'd0, ATAN_TAB[iter]});
    if (!z[ROT_W-1]) begin
      nx = x - ys;
      ny = y + xs;
      nz = z - at;
    end else begin
      nx = x + ys;
      ny = y - xs;
      nz = z + at;
    end
    xr = (nx + ROUND_C) >>> (30 - FRAC_BITS);
    yr = (ny + ROUND_C) >>> (30 - FRAC_BITS);
    cx = clamp_unit(xr);
    sy = clamp_unit(yr);
  end

  // Shared multiplier and its operand selection.
  logic signed [48:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic                    mul_done;
  logic signed [63:0]      mul_r;
  logic signed [ANG_W-1:0] ang_abs;

  assign ang_abs = ang[ANG_W-1] ? -ang : ang;

  always_comb begin
    case (cmd.op)
      OP_PPX:  begin mul_a = $signed({25'd0, cfg.preview_dist}); mul_b = 33'(c); end
      OP_PPY:  begin mul_a = $signed({25'd0, cfg.preview_dist}); mul_b = 33'(s); end
      OP_PX:   begin mul_a = 49'(dx);         mul_b = $signed({9'd0, cfg.prop_gain}); end
      OP_IX:   begin mul_a = 49'(integ_x);    mul_b = $signed({9'd0, cfg.integ_gain}); end
      OP_PY:   begin mul_a = 49'(dy);         mul_b = $signed({9'd0, cfg.prop_gain}); end
      OP_IY:   begin mul_a = 49'(integ_y);    mul_b = $signed({9'd0, cfg.integ_gain}); end
      OP_LX:   begin mul_a = 49'(held_vel_x); mul_b = 33'(c); end
      OP_LY:   begin mul_a = 49'(held_vel_y); mul_b = 33'(s); end
      OP_AY:   begin mul_a = 49'(held_vel_y); mul_b = 33'(c); end
      OP_AX:   begin mul_a = 49'(held_vel_x); mul_b = 33'(s); end
      OP_ANG:  begin mul_a = 49'(diff); mul_b = $signed({1'b0, cfg.preview_recip}); end
      OP_FAC:  begin mul_a = 49'(ang_abs); mul_b = $signed({1'b0, cfg.max_angular_recip}); end
      OP_LIM:  begin
        mul_a = $signed({25'd0, cfg.max_linear});
        mul_b = $signed(33'(factor));
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  ttpi_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_r)
  );

  logic signed [63:0]      wmax;
  logic signed [64:0]      fac_full;
  logic signed [LIN_W-1:0] lin_c;

  assign wmax     = $signed({40'd0, cfg.max_angular});
  assign fac_full = F_ONE - 65'(mul_r);

  always_comb begin
    if (lin > lim) lin_c = lim;
    else if (lin < -lim) lin_c = -lim;
    else lin_c = lin;
  end

  assign sts.run         = run;
  assign sts.cordic_done = cordic_done;
  assign sts.mul_done    = mul_done;
  assign sts.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_busy    <= 1'b0;
      cordic_done <= 1'b0;
      out_valid   <= 1'b0;
      integ_x     <= '0;
      integ_y     <= '0;
      held_vel_x  <= '0;
      held_vel_y  <= '0;
      tick_count  <= '0;
      run         <= 1'b0;
    end else begin
      cordic_done <= 1'b0;

      if (cmd.load) begin
        px       <= in_data.pos_x;
        py       <= in_data.pos_y;
        rx       <= in_data.ref_x;
        ry       <= in_data.ref_y;
        rvx      <= in_data.ref_vx;
        rvy      <= in_data.ref_vy;
        x        <= X_INIT;
        y        <= '0;
        z        <= ROT_W'($signed(z0));
        flip     <= quad_flip;
        iter     <= '0;
        rot_busy <= 1'b1;
        run      <= (eff_tick == 8'd0);
        tick_count <= (tick_inc >= {1'b0, ratio}) ? 8'd0 : tick_inc[7:0];
        if (in_data.restart) begin
          integ_x <= '0;
          integ_y <= '0;
        end
      end

      if (rot_busy) begin
        x    <= nx;
        y    <= ny;
        z    <= nz;
        iter <= iter + 5'd1;
        if (iter == 5'(CORDIC_STEPS - 1)) begin
          rot_busy    <= 1'b0;
          cordic_done <= 1'b1;
          c <= flip ? -cx : cx;
          s <= flip ? -sy : sy;
        end
      end

      if (cmd.mul_start) op_q <= cmd.op;

      if (cmd.integ) begin
        integ_x <= sat48(49'(integ_x) + 49'(dx));
        integ_y <= sat48(49'(integ_y) + 49'(dy));
      end

      if (mul_done) begin
        case (op_q)
          OP_PPX: dx <= DX_W'(rx) - DX_W'(px) - mul_r[DX_W-1:0];
          OP_PPY: dy <= DX_W'(ry) - DX_W'(py) - mul_r[DX_W-1:0];
          OP_PX:  vel_acc <= 66'(rvx) + 66'(mul_r);
          OP_IX:  held_vel_x <= sat32(vel_acc + 66'(mul_r));
          OP_PY:  vel_acc <= 66'(rvy) + 66'(mul_r);
          OP_IY:  held_vel_y <= sat32(vel_acc + 66'(mul_r));
          OP_LX:  lin <= mul_r[LIN_W-1:0];
          OP_LY:  lin <= lin + mul_r[LIN_W-1:0];
          OP_AY:  diff <= mul_r[LIN_W-1:0];
          OP_AX:  diff <= diff - mul_r[LIN_W-1:0];
          OP_ANG: begin
            if (mul_r > wmax) ang <= wmax[ANG_W-1:0];
            else if (mul_r < -wmax) ang <= -wmax[ANG_W-1:0];
            else ang <= mul_r[ANG_W-1:0];
          end
          // A negative speed factor stops the robot.
          OP_FAC: factor <= fac_full[64] ? '0 : fac_full[FRAC_BITS:0];
          OP_LIM: lim <= mul_r[LIN_W-1:0];
          default: ;
        endcase
      end

      if (cmd.emit) begin
        out_valid            <= 1'b1;
        out_data.linear_cmd  <= lin_c[31:0];
        out_data.angular_cmd <= 32'(ang);
        out_data.pi_updated  <= run;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/trajectory_tracking_pi_controller_top.sv */
// Latency is set by the 24-step CORDIC and up to 13 products on the shared multiplier;
// a tick that runs the PI update takes the longest.
// Throughput: one tick at a time; the next beat is taken once the result is in the
// output register, which holds it until taken. Reset is synchronous and active high,
// restores register defaults and clears integrators, held velocities and the tick count.
`default_nettype none

module trajectory_tracking_pi_controller_top #(
  parameter int FRAC_BITS = ttpi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ttpi_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ttpi_pkg::out_beat_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttpi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ttpi_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  ttpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttpi_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* design/ttpi_checker.sv */
// Port-level assertions for the controller top, attached by bind.
// Depends on ttpi_pkg for the beat types.
`default_nettype none

module ttpi_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ttpi_pkg::out_beat_t out_data
);

  // A held result beat must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One tick is worked at a time, so an accepted beat drops ready.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // Both commands stay inside the 24-bit limit registers.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_data.linear_cmd) < 32'sd16777216
               && $signed(out_data.linear_cmd) > -32'sd16777216
               && $signed(out_data.angular_cmd) < 32'sd16777216
               && $signed(out_data.angular_cmd) > -32'sd16777216)
    else $error("command beyond its limit");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind trajectory_tracking_pi_controller_top ttpi_checker u_ttpi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
